>>> src/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg: shared types and constants for the vertex normal accumulator
// Command codes, payload structs and widths used by all modules.
// ----------------------------------------------------------------------------
`default_nettype none
package vna_pkg;
  localparam int VERTEX_DEPTH = 1024;
  localparam int IDX_BITS     = $clog2(VERTEX_DEPTH);
  localparam int COORD_BITS   = 16;
  localparam int SUM_BITS     = 48;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TRI   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [9:0]         index_a;
    logic [9:0]         index_b;
    logic [9:0]         index_c;
  } vna_in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [9:0]         vertex_id;
    logic               zero_length;
  } vna_out_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  // Saturating add of a face normal component into a running sum.
  function automatic sum_t sat_add(input sum_t s, input logic signed [35:0] f);
    logic signed [SUM_BITS:0] w;
    logic signed [SUM_BITS:0] hi;
    logic signed [SUM_BITS:0] lo;
    hi = (SUM_BITS+1)'({1'b0, {(SUM_BITS-1){1'b1}}});
    lo = -hi - (SUM_BITS+1)'(1);
    w  = (SUM_BITS+1)'(s) + (SUM_BITS+1)'(f);
    if (w > hi) return hi[SUM_BITS-1:0];
    if (w < lo) return lo[SUM_BITS-1:0];
    return w[SUM_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

>>> src/vertex_normal_accumulator_unit.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_unit: area-weighted smooth vertex normals
// Position and sum memories with a sequencer for write, triangle and read.
// ----------------------------------------------------------------------------
// The block handles one command beat at a time. After a write the next
// beat can be taken on the following edge. A triangle is paced by the
// single read port of each memory: three position reads, each a read and a
// wait, then the edges, the cross products and the face normal, then three
// read-modify-write passes on the sums, each a read, a wait for the
// registered data and an add-and-write. A read of a nonzero sum is paced
// by the normalizer: a bit-serial square root of 32 steps and three 45-step
// restoring divisions; a read of a zero sum skips both. Sums are cleared by
// a vertex write and by a clearing pass over all 1024 entries after reset,
// during which no beat is accepted. The result sits in an output register
// so the next command can be taken while it waits; a later read that
// finishes while that register is still full holds its result until the
// register frees up.
`default_nettype none
module vertex_normal_accumulator_unit import vna_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire vna_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output vna_out_t     out_data
);
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_PRD = 4'd2,
                         S_PWAIT = 4'd3, S_CROSS = 4'd4, S_CROSS2 = 4'd5,
                         S_SRD = 4'd6, S_SWAIT = 4'd7, S_SWR = 4'd8,
                         S_RRD = 4'd9, S_RWAIT = 4'd10, S_NORM = 4'd11,
                         S_NDONE = 4'd12;

  logic [3:0] state;
  logic [IDX_BITS-1:0] clr_idx;

  logic [3*COORD_BITS-1:0] pos_mem [VERTEX_DEPTH];
  logic [3*SUM_BITS-1:0]   sum_mem [VERTEX_DEPTH];
  logic [3*COORD_BITS-1:0] pos_q;
  logic [3*SUM_BITS-1:0]   sum_q;

  logic [IDX_BITS-1:0] idx [3];
  logic [1:0]  k;
  logic signed [COORD_BITS:0] pa [3];
  logic signed [COORD_BITS:0] pb [3];
  logic signed [COORD_BITS:0] pc [3];
  logic signed [35:0] prod [6];
  logic signed [35:0] face [3];
  sum_t nsx, nsy, nsz;

  logic norm_start, norm_busy, norm_done, norm_zero;
  logic signed [15:0] nx, ny, nz;

  logic pos_we, sum_we, pos_re, sum_re;
  logic [IDX_BITS-1:0] pos_wa, sum_wa, pos_ra, sum_ra;
  logic [3*COORD_BITS-1:0] pos_wd;
  logic [3*SUM_BITS-1:0]   sum_wd;

  // The output register is free when empty or being taken this cycle. The
  // normalizer keeps its result steady while idle, so a finished read can
  // wait in S_NDONE for the register.
  logic out_free, out_load;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign out_load = ((state == S_NORM && norm_done) || state == S_NDONE) && out_free;

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (pos_re) pos_q <= pos_mem[pos_ra];
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    if (sum_re) sum_q <= sum_mem[sum_ra];
  end

  always_comb begin
    pos_we = (state == S_IDLE) && in_valid && in_ready && (in_data.command == CMD_WRITE);
    pos_wa = in_data.index_a[IDX_BITS-1:0];
    pos_wd = {COORD_BITS'(in_data.pos_x), COORD_BITS'(in_data.pos_y),
              COORD_BITS'(in_data.pos_z)};
    pos_re = (state == S_PRD);
    pos_ra = idx[k];
    sum_re = (state == S_SRD) || (state == S_RRD);
    sum_ra = idx[k];
    sum_we = (state == S_CLR) || pos_we || (state == S_SWR);
    sum_wa = (state == S_CLR) ? clr_idx : (state == S_SWR) ? idx[k] : pos_wa;
    sum_wd = (state == S_SWR) ? {nsx, nsy, nsz} : '0;
    nsx = sat_add(sum_q[3*SUM_BITS-1:2*SUM_BITS], face[0]);
    nsy = sat_add(sum_q[2*SUM_BITS-1:SUM_BITS], face[1]);
    nsz = sat_add(sum_q[SUM_BITS-1:0], face[2]);
    norm_start = (state == S_RWAIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (out_load) begin
        out_data.normal_x <= nx;
        out_data.normal_y <= ny;
        out_data.normal_z <= nz;
        out_data.zero_length <= norm_zero;
        out_data.vertex_id <= 10'(idx[0]);
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + IDX_BITS'(1);
          if (clr_idx == IDX_BITS'(VERTEX_DEPTH-1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            idx[0] <= in_data.index_a[IDX_BITS-1:0];
            idx[1] <= in_data.index_b[IDX_BITS-1:0];
            idx[2] <= in_data.index_c[IDX_BITS-1:0];
            k <= '0;
            if (in_data.command == CMD_TRI) state <= S_PRD;
            else if (in_data.command == CMD_READ) state <= S_RRD;
          end
        end
        S_PRD: state <= S_PWAIT;
        S_PWAIT: begin
          for (int i = 0; i < 3; i++) begin
            if (k == 2'd0) pa[i] <= (COORD_BITS+1)'($signed(pos_q[(3-i)*COORD_BITS-1 -: COORD_BITS]));
            if (k == 2'd1) pb[i] <= (COORD_BITS+1)'($signed(pos_q[(3-i)*COORD_BITS-1 -: COORD_BITS]));
            if (k == 2'd2) pc[i] <= (COORD_BITS+1)'($signed(pos_q[(3-i)*COORD_BITS-1 -: COORD_BITS]));
          end
          if (k == 2'd2) begin
            state <= S_CROSS;
          end else begin
            k <= k + 2'd1;
            state <= S_PRD;
          end
        end
        S_CROSS: begin
          // Edges B-A and C-A are formed in place, products next cycle.
          for (int i = 0; i < 3; i++) begin
            pb[i] <= pb[i] - pa[i];
            pc[i] <= pc[i] - pa[i];
          end
          state <= S_CROSS2;
          k <= '0;
        end
        S_CROSS2: begin
          if (k == 2'd0) begin
            prod[0] <= pb[1] * pc[2]; prod[1] <= pb[2] * pc[1];
            prod[2] <= pb[2] * pc[0]; prod[3] <= pb[0] * pc[2];
            prod[4] <= pb[0] * pc[1]; prod[5] <= pb[1] * pc[0];
            k <= 2'd1;
          end else begin
            face[0] <= prod[0] - prod[1];
            face[1] <= prod[2] - prod[3];
            face[2] <= prod[4] - prod[5];
            k <= '0;
            state <= S_SRD;
          end
        end
        S_SRD: state <= S_SWAIT;
        S_SWAIT: state <= S_SWR;
        S_SWR: begin
          if (k == 2'd2) state <= S_IDLE;
          else begin
            k <= k + 2'd1;
            state <= S_SRD;
          end
        end
        S_RRD: state <= S_RWAIT;
        S_RWAIT: state <= S_NORM;
        S_NORM: begin
          if (norm_done) state <= out_free ? S_IDLE : S_NDONE;
        end
        S_NDONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  vna_norm u_norm (
    .clk(clk), .rst(rst), .start(norm_start),
    .sx(sum_q[3*SUM_BITS-1:2*SUM_BITS]),
    .sy(sum_q[2*SUM_BITS-1:SUM_BITS]),
    .sz(sum_q[SUM_BITS-1:0]),
    .busy(norm_busy), .done(norm_done),
    .nx(nx), .ny(ny), .nz(nz), .zero(norm_zero)
  );

  logic unused_busy;
  assign unused_busy = norm_busy;
endmodule
`default_nettype wire

>>> src/vna_norm.sv
// ----------------------------------------------------------------------------
// vna_norm: normalizer for one accumulated sum
// Scales the magnitudes, forms the squared length, takes an integer square
// root bit by bit and divides each component by restoring division.
// ----------------------------------------------------------------------------
`default_nettype none
module vna_norm import vna_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire sum_t     sx,
  input  wire sum_t     sy,
  input  wire sum_t     sz,
  output logic          busy,
  output logic          done,
  output logic signed [15:0] nx,
  output logic signed [15:0] ny,
  output logic signed [15:0] nz,
  output logic          zero
);
  localparam logic [2:0] S_IDLE = 3'd0, S_TOP = 3'd1, S_SCALE = 3'd2,
                         S_SQ = 3'd3, S_ROOT = 3'd4, S_DIV = 3'd5;

  logic [2:0]  state;
  logic [SUM_BITS-1:0] a [3];
  logic [2:0]  neg;
  logic [5:0]  top;
  logic [1:0]  k;
  logic [63:0] m;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [5:0]  cnt;
  logic [45:0] rem;
  logic [44:0] num;
  logic [15:0] q;
  // The root of three squares below 2^60 can reach 31 bits.
  logic [30:0] len;
  logic [15:0] res [3];

  logic [SUM_BITS-1:0] mx;
  logic [5:0]          top_c;
  logic [45:0]         rem_sh;

  always_comb begin
    mx = a[0];
    if (a[1] > mx) mx = a[1];
    if (a[2] > mx) mx = a[2];
    top_c = '0;
    for (int i = 0; i < SUM_BITS; i++) begin
      if (mx[i]) top_c = 6'(i);
    end
    rem_sh = {rem[44:0], num[44]};
  end

  assign busy = (state != S_IDLE);
  assign nx = res[0];
  assign ny = res[1];
  assign nz = res[2];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            a[0] <= sx[SUM_BITS-1] ? SUM_BITS'(-sx) : SUM_BITS'(sx);
            a[1] <= sy[SUM_BITS-1] ? SUM_BITS'(-sy) : SUM_BITS'(sy);
            a[2] <= sz[SUM_BITS-1] ? SUM_BITS'(-sz) : SUM_BITS'(sz);
            neg <= {sz[SUM_BITS-1], sy[SUM_BITS-1], sx[SUM_BITS-1]};
            state <= S_TOP;
          end
        end
        S_TOP: begin
          if (mx == '0) begin
            zero <= 1'b1;
            res[0] <= '0; res[1] <= '0; res[2] <= '0;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            zero <= 1'b0;
            top <= top_c;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          for (int i = 0; i < 3; i++) begin
            if (top > 6'd29) a[i] <= a[i] >> (top - 6'd29);
            else a[i] <= a[i] << (6'd29 - top);
          end
          m <= '0;
          k <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          // One 30x30 square per cycle.
          m <= m + 64'(a[k][29:0] * a[k][29:0]);
          if (k == 2'd2) begin
            r <= '0;
            bitv <= 64'd1 << 62;
            state <= S_ROOT;
          end
          k <= k + 2'd1;
        end
        S_ROOT: begin
          if (bitv == '0) begin
            len <= r[30:0];
            k <= '0;
            num <= 45'(a[0][29:0]) * 45'd16384 + 45'(r[30:1]);
            rem <= '0;
            cnt <= '0;
            state <= S_DIV;
          end else begin
            if (m >= r + bitv) begin
              m <= m - (r + bitv);
              r <= (r >> 1) + bitv;
            end else begin
              r <= r >> 1;
            end
            bitv <= bitv >> 2;
          end
        end
        S_DIV: begin
          if (cnt == 6'd45) begin
            res[k] <= neg[k] ? 16'(-q) : q;
            if (k == 2'd2) begin
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              num <= 45'(a[k+2'd1][29:0]) * 45'd16384 + 45'(len[30:1]);
              rem <= '0;
              cnt <= '0;
            end
            k <= k + 2'd1;
          end else begin
            if (rem_sh >= 46'(len)) begin
              rem <= rem_sh - 46'(len);
              q <= {q[14:0], 1'b1};
            end else begin
              rem <= rem_sh;
              q <= {q[14:0], 1'b0};
            end
            num <= {num[43:0], 1'b0};
            cnt <= cnt + 6'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/vna_checker.sv
// ----------------------------------------------------------------------------
// vna_port_checks: port-level checks for the vertex normal accumulator
// Watches the two handshakes and the result payload.
// ----------------------------------------------------------------------------
`default_nettype none
module vna_port_checks import vna_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire vna_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire vna_out_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_zero_vec: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_length |->
      out_data.normal_x == 16'sd0 && out_data.normal_y == 16'sd0 &&
      out_data.normal_z == 16'sd0)
    else $error("zero-length beat carries nonzero normal");

  // Triangles and reads keep the block busy, so it is not ready right after one is taken.
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
      (in_data.command == CMD_TRI || in_data.command == CMD_READ) |=> !in_ready)
    else $error("second command taken right after a triangle or read");

  a_no_out_in_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");
endmodule

bind vertex_normal_accumulator_unit vna_port_checks u_vna_port_checks (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);
`default_nettype wire
